// ----- rtl/stereo_echo_reverb_comb_macros.svh -----
// Assertion macros for the stereo echo / reverb comb filter.
// Included by the top level; needs no other file.
`ifndef STEREO_ECHO_REVERB_COMB_MACROS_SVH
`define STEREO_ECHO_REVERB_COMB_MACROS_SVH

// pre and post in the same cycle
`define SERC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// post in the cycle after pre
`define SERC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/serc_pkg.sv -----
// Shared types, constants and the mixing function of the comb filter.
// No dependencies.
package serc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEN_W      = 13;
   localparam int GAIN_W     = 8;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd2;

   localparam logic              MODE_RESET   = 1'b0;
   localparam logic [LEN_W-1:0]  LENGTH_RESET = 13'd4000;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 8'd128;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } lane_ctl_type;

   // (x*256 + g*d) / 256, truncated toward zero, saturated to 16 bits
   function automatic sample_type mix_sample(input sample_type x, input sample_type d,
                                             input logic [GAIN_W-1:0] g);
      logic signed [25:0] prod;
      logic signed [25:0] sum;
      logic signed [25:0] adj;
      logic signed [17:0] q;
      prod = d * $signed({1'b0, g});
      sum  = prod + (26'(x) <<< 8);
      adj  = sum + (sum[25] ? 26'sd255 : 26'sd0);
      q    = 18'(adj >>> 8);
      if (q > 18'sd32767) begin
         mix_sample = 16'sh7FFF;
      end else if (q < -18'sd32768) begin
         mix_sample = 16'sh8000;
      end else begin
         mix_sample = q[15:0];
      end
   endfunction

endpackage

// ----- rtl/stereo_echo_reverb_comb.sv -----
// Pipeline: ring read into stage one (s1_valid_ff), then the serc_merge output register.
// Throughput: one request per cycle unless rsp_tready stalls; the ring read is
// issued on acceptance, the previous sample's write is bypassed, so delay 1 still streams.
// Reset: synchronous; then all RING_DEPTH ring addresses are cleared, req_tready low.
// Registers reset to echo mode, length 4000, gain 128.
module stereo_echo_reverb_comb #(
   parameter int RING_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,  // left_in [15:0], right_in [31:16]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // left_out [15:0], right_out [31:16]
   input  logic                            csr_we,
   input  logic [serc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [serc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import serc_pkg::*;
`include "stereo_echo_reverb_comb_macros.svh"

   localparam int AW = $clog2(RING_DEPTH);
   localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
   localparam logic [LW-1:0] MAX_LEN   = LW'(RING_DEPTH);
   localparam logic [LW-1:0] MIN_LEN   = LW'(2);

   logic              mode_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [AW-1:0]     write_pos_ff;
   logic              s1_valid_ff;
   logic [AW-1:0]     s1_pos_ff;
   logic              clearing_ff;
   logic [AW-1:0]     clr_ff;

   logic [LW-1:0] len_raw, len_eff, rd_ext;
   logic [AW-1:0] pos, rd;
   logic          take, req_fire, advance;
   lane_ctl_type  ctl;
   logic [AW-1:0] wr_addr;
   sample_type    y_left, y_right;

   always_comb begin
      len_raw = LW'(length_ff);
      if (len_raw < MIN_LEN) begin
         len_eff = MIN_LEN;
      end else if (len_raw > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = len_raw;
      end
      pos    = (LW'(write_pos_ff) >= len_eff) ? '0 : write_pos_ff;
      rd_ext = LW'(pos) + LW'(1);
      rd     = (rd_ext >= len_eff) ? '0 : rd_ext[AW-1:0];
   end

   assign req_tready = !clearing_ff && (!s1_valid_ff || take);
   assign req_fire   = req_tvalid && req_tready;
   assign advance    = s1_valid_ff && take;

   assign ctl.rd_en = req_fire;
   assign ctl.wr_en = clearing_ff || advance;
   assign ctl.clear = clearing_ff;
   assign wr_addr   = clearing_ff ? clr_ff : s1_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         length_ff    <= LENGTH_RESET;
         gain_ff      <= GAIN_RESET;
         write_pos_ff <= '0;
         s1_valid_ff  <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[0];
               CSR_LENGTH: length_ff <= csr_wdata[LEN_W-1:0];
               CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
               default:    ;
            endcase
         end
         if (clearing_ff) begin
            clr_ff <= clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end
         end
         if (req_fire) begin
            write_pos_ff <= rd;
            s1_valid_ff  <= 1'b1;
         end else if (advance) begin
            s1_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pos_ff <= pos;
      end
   end

   serc_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_addr (rd),
      .wr_addr (wr_addr),
      .x_in    (req_tdata[15:0]),
      .mode    (mode_ff),
      .gain    (gain_ff),
      .y       (y_left)
   );

   serc_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_addr (rd),
      .wr_addr (wr_addr),
      .x_in    (req_tdata[31:16]),
      .mode    (mode_ff),
      .gain    (gain_ff),
      .y       (y_right)
   );

   serc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (s1_valid_ff),
      .left       (y_left),
      .right      (y_right),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `SERC_ASSERT_NOW(a_no_req_while_clearing, clock, reset, clearing_ff, !req_tready,
      "request accepted during ring clear")
   `SERC_ASSERT_NOW(a_no_req_while_stalled, clock, reset, s1_valid_ff && !take, !req_tready,
      "request accepted while stage one is stalled")
   `SERC_ASSERT_NEXT(a_pos_in_range, clock, reset, req_fire && !csr_we,
      LW'(write_pos_ff) < len_eff, "write position beyond ring length")
endmodule

// ----- rtl/serc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module serc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/serc_lane.sv -----
// One channel of the comb filter: input and output rings, write bypass, mixer.
// Depends on serc_pkg and serc_ram.
module serc_lane #(
   parameter int RING_DEPTH = 4096,
   localparam int AW = $clog2(RING_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  serc_pkg::lane_ctl_type ctl,
   input  logic [AW-1:0]         rd_addr,
   input  logic [AW-1:0]         wr_addr,
   input  serc_pkg::sample_type  x_in,
   input  logic                  mode,
   input  logic [7:0]            gain,
   output serc_pkg::sample_type  y
);
   import serc_pkg::*;

   sample_type x_ff;
   sample_type byp_in_ff;
   sample_type byp_out_ff;
   logic       hit_ff, hit_in;
   sample_type in_q, out_q;
   sample_type wdata_in_ring, wdata_out_ring;
   sample_type delayed;

   assign hit_in = ctl.wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         x_ff       <= x_in;
         byp_in_ff  <= wdata_in_ring;
         byp_out_ff <= wdata_out_ring;
      end
   end

   always_comb begin
      if (hit_ff) begin
         delayed = mode ? byp_out_ff : byp_in_ff;
      end else begin
         delayed = mode ? out_q : in_q;
      end
   end

   assign y              = mix_sample(x_ff, delayed, gain);
   assign wdata_in_ring  = ctl.clear ? '0 : x_ff;
   assign wdata_out_ring = ctl.clear ? '0 : y;

   serc_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_in_ring (
      .clock (clock),
      .we    (ctl.wr_en),
      .waddr (wr_addr),
      .wdata (wdata_in_ring),
      .re    (ctl.rd_en),
      .raddr (rd_addr),
      .rdata (in_q)
   );

   serc_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_out_ring (
      .clock (clock),
      .we    (ctl.wr_en),
      .waddr (wr_addr),
      .wdata (wdata_out_ring),
      .re    (ctl.rd_en),
      .raddr (rd_addr),
      .rdata (out_q)
   );
endmodule

// ----- rtl/serc_merge.sv -----
// Output register joining the two lane results into one response.
// Depends on serc_pkg.
module serc_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  serc_pkg::sample_type left,
   input  serc_pkg::sample_type right,
   output logic                 take,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata    // left_out [15:0], right_out [31:16]
);
   import serc_pkg::*;

   logic        valid_ff;
   logic [31:0] data_ff;

   assign take = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && valid_in) begin
         data_ff <= {right, left};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
endmodule

// ----- bench/tb.sv -----
// Self-checking bench for stereo_echo_reverb_comb: drives stereo requests, predicts
// every response with its own echo/reverb comb and compares the two sample fields.
// Depends on serc_pkg and the stereo_echo_reverb_comb RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import serc_pkg::*;

   localparam int RING_DEPTH  = 4096;
   localparam int RANDOM_REQS = 1530;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // bench copy of the registers and the rings
   logic             mode_now   = MODE_RESET;
   logic [LEN_W-1:0] length_now = LENGTH_RESET;
   logic [7:0]       gain_now   = GAIN_RESET;
   sample_type       in_ring_l  [RING_DEPTH] = '{default: '0};
   sample_type       in_ring_r  [RING_DEPTH] = '{default: '0};
   sample_type       out_ring_l [RING_DEPTH] = '{default: '0};
   sample_type       out_ring_r [RING_DEPTH] = '{default: '0};
   int               write_pos = 0;

   logic [31:0] pairs_to_send[$];
   logic [31:0] pairs_due[$];
   int          req_queued   = 0;
   int          req_accepted = 0;
   int          pairs_checked = 0;
   int          settings_used = 0;
   int          fails = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_request = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   bit          req_taken = 1'b0;

   stereo_echo_reverb_comb #(.RING_DEPTH(RING_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // left_in [15:0], right_in [31:16]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // left_out [15:0], right_out [31:16]
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // input plus gain/256 of the delayed sample, truncated toward zero, saturated
   function automatic sample_type mixed_sample(input int x, input int d);
      int sum;
      int q;
      sum = x * 256 + int'(gain_now) * d;
      q = sum / 256;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return sample_type'(q);
   endfunction

   function automatic logic [31:0] comb_predict(input logic [31:0] pair);
      int         len;
      int         pos;
      int         rd;
      int         dl;
      int         dr;
      sample_type xl;
      sample_type xr;
      sample_type yl;
      sample_type yr;
      len = int'(length_now);
      if (len < 2) len = 2;
      if (len > RING_DEPTH) len = RING_DEPTH;
      pos = write_pos;
      if (pos >= len) pos = 0;
      rd = pos + 1;
      if (rd >= len) rd = 0;
      xl = pair[15:0];
      xr = pair[31:16];
      if (mode_now) begin
         dl = out_ring_l[rd];
         dr = out_ring_r[rd];
      end else begin
         dl = in_ring_l[rd];
         dr = in_ring_r[rd];
      end
      yl = mixed_sample(xl, dl);
      yr = mixed_sample(xr, dr);
      in_ring_l[pos]  = xl;
      in_ring_r[pos]  = xr;
      out_ring_l[pos] = yl;
      out_ring_r[pos] = yr;
      write_pos = rd;
      return {yr, yl};
   endfunction

   // request driver
   always @(negedge clock) begin
      logic        next_valid;
      logic [31:0] next_data;
      next_valid = 1'b0;
      next_data  = req_tdata;
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            next_valid = 1'b1;
         end else if (pairs_to_send.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            next_valid = 1'b1;
            next_data  = pairs_to_send.pop_front();
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // response back-pressure, with a long hold on request
   always @(negedge clock) begin
      if (hold_seen != hold_request) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // monitor: register copy, prediction and response check
   always @(posedge clock) begin
      logic [31:0] due;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pairs_due.size());
         $display("tb NOT OK");
         $finish;
      end else begin
         req_taken = 1'b0;
         if (!reset) begin
            if (csr_we) begin
               case (csr_index)
                  CSR_MODE:   mode_now   = csr_wdata[0];
                  CSR_LENGTH: length_now = csr_wdata[LEN_W-1:0];
                  CSR_GAIN:   gain_now   = csr_wdata[7:0];
                  default: ;
               endcase
            end
            if (rsp_tvalid && rsp_tready) begin
               if (pairs_due.size() == 0) begin
                  $error("response %h with no request outstanding", rsp_tdata);
                  fails++;
               end else begin
                  due = pairs_due.pop_front();
                  if (rsp_tdata[15:0] !== due[15:0]) begin
                     $error("left_out expected %0d got %0d",
                            $signed(due[15:0]), $signed(rsp_tdata[15:0]));
                     fails++;
                  end
                  if (rsp_tdata[31:16] !== due[31:16]) begin
                     $error("right_out expected %0d got %0d",
                            $signed(due[31:16]), $signed(rsp_tdata[31:16]));
                     fails++;
                  end
                  pairs_checked++;
               end
            end
            if (req_tvalid && req_tready) begin
               pairs_due.push_back(comb_predict(req_tdata));
               req_accepted++;
               req_taken = 1'b1;
            end
         end
      end
   end

   task automatic send_pair(input logic [15:0] left, input logic [15:0] right);
      pairs_to_send.push_back({right, left});
      req_queued++;
   endtask

   // wait for every request to be answered, then let the pipeline empty
   task automatic settle();
      while (req_accepted != req_queued || pairs_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_idling(input idling_type kind);
      case (kind)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 64; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 64; end
         default:       begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      settings_used++;
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(9, 0))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom_range(16, 0) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int          phase;
      int          burst;
      logic [12:0] len_val;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset registers: echo, long ring, gain one half
      set_idling(IDLE_NONE);
      send_pair(16'h7FFF, 16'h8000);
      send_pair(16'h8000, 16'h7FFF);
      send_pair(16'h0000, 16'h0000);
      send_pair(16'hFFFF, 16'h0001);
      settle();

      // echo, length below range (used as 2), full gain, spare index ignored
      csr_write(CSR_MODE, 13'd0);
      csr_write(CSR_LENGTH, 13'd0);
      csr_write(CSR_GAIN, 13'd255);
      csr_write(CSR_SPARE, 13'($urandom));
      set_idling(IDLE_SENDER);
      send_pair(16'h7FFF, 16'h7FFF);
      send_pair(16'h7FFF, 16'h8000);
      send_pair(16'h8000, 16'h8000);
      send_pair(16'hFFFF, 16'h0001);
      send_pair(16'h0000, 16'h0000);
      send_pair(16'h0001, 16'hFFFF);
      send_pair(16'h0000, 16'h0000);
      settle();

      // reverb, length 1 (used as 2), smallest nonzero gain: truncation toward zero
      csr_write(CSR_MODE, 13'd1);
      csr_write(CSR_LENGTH, 13'd1);
      csr_write(CSR_GAIN, 13'd1);
      set_idling(IDLE_RECEIVER);
      send_pair(16'hFFFF, 16'h0001);
      send_pair(16'h0000, 16'h0000);
      send_pair(16'd300, -16'sd300);
      send_pair(16'h7FFF, 16'h8000);
      send_pair(16'h7FFF, 16'h8000);
      settle();

      // length above the ring (used as full depth), zero gain
      csr_write(CSR_MODE, 13'd0);
      csr_write(CSR_LENGTH, 13'd8191);
      csr_write(CSR_GAIN, 13'd0);
      set_idling(IDLE_BOTH);
      send_pair(16'h8000, 16'h7FFF);
      send_pair(16'h1234, 16'hEDCB);
      send_pair(16'h7FFF, 16'h8000);
      settle();

      phase = 0;
      while (req_queued < RANDOM_REQS + 19) begin
         case ($urandom_range(19, 0))
            0:       len_val = 13'd0;
            1:       len_val = 13'd1;
            2:       len_val = 13'd4096;
            3:       len_val = 13'($urandom_range(8191, 4097));
            4:       len_val = 13'($urandom_range(4095, 300));
            5, 6, 7: len_val = 13'($urandom_range(299, 41));
            default: len_val = 13'($urandom_range(40, 2));
         endcase
         csr_write(CSR_MODE, 13'($urandom));
         csr_write(CSR_LENGTH, len_val);
         case ($urandom_range(5, 0))
            0:       csr_write(CSR_GAIN, 13'd0);
            1:       csr_write(CSR_GAIN, 13'd255);
            default: csr_write(CSR_GAIN, 13'($urandom));
         endcase
         if (phase == 2) begin
            // receiver holds off while requests keep coming
            set_idling(IDLE_NONE);
            hold_request++;
         end else begin
            set_idling(idling_type'(phase % 4));
         end
         burst = $urandom_range(100, 40);
         repeat (burst) send_pair(random_sample(), random_sample());
         settle();
         phase++;
      end

      repeat (8) @(posedge clock);
      $display("%0d stereo pairs checked over %0d register settings, echo and reverb,",
               pairs_checked, settings_used);
      $display("ring lengths clamped at both ends, gains 0 to 255, %0d mismatches", fails);
      if (fails == 0 && pairs_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/serc_pkg.sv
rtl/serc_ram.sv
rtl/serc_lane.sv
rtl/serc_merge.sv
rtl/stereo_echo_reverb_comb.sv
bench/tb.sv
